>>> rtl/ipd_pkg.sv
// Shared types, constants and an angle helper for the IMU packet deframer.
`default_nettype none

package ipd_pkg;

  localparam int unsigned FRAME_BYTES = 26;
  localparam int unsigned CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [7:0] SYNC_BYTE = 8'hA6;

  typedef logic signed [17:0] angle_t;

  localparam angle_t HALF_TURN = 18'sd18000;
  localparam angle_t FULL_TURN = 18'sd36000;

  typedef enum logic [1:0] {
    ACT_BYTE   = 2'd0,
    ACT_REZERO = 2'd1,
    ACT_CLEAR  = 2'd2
  } action_e;

  typedef struct packed {
    action_e            action;
    logic [7:0]         rx_byte;
    logic signed [15:0] target_yaw;
  } in_t;

  typedef struct packed {
    logic signed [15:0] yaw_rel;
    logic signed [15:0] pitch_rel;
    logic signed [15:0] roll_rel;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } out_t;

  // Folds an angle difference back by one full turn if it lies outside a half turn.
  function automatic angle_t wrap_once(angle_t d);
    angle_t r;
    r = d;
    if (d > HALF_TURN) begin
      r = d - FULL_TURN;
    end else if (d < -HALF_TURN) begin
      r = d + FULL_TURN;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ipd_cell.sv
// One byte cell of the deframer's shift line.
`default_nettype none

module ipd_cell
  import ipd_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       shift_i,
  input  wire logic [7:0] byte_i,
  output logic      [7:0] byte_o
);

  logic [7:0] byte_q;
  logic [7:0] byte_d;

  assign byte_d = shift_i ? byte_i : byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= '0;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

`default_nettype wire

>>> rtl/ipd_rel.sv
// Wraps and saturates one relative angle into plus or minus a half turn.
`default_nettype none

module ipd_rel
  import ipd_pkg::*;
(
  input  wire angle_t             diff_i,
  output logic signed [15:0]      rel_o
);

  angle_t wrapped;
  angle_t clipped;

  always_comb begin
    wrapped = wrap_once(diff_i);
    clipped = wrapped;
    if (wrapped > HALF_TURN) begin
      clipped = HALF_TURN;
    end else if (wrapped < -HALF_TURN) begin
      clipped = -HALF_TURN;
    end
    rel_o = clipped[15:0];
  end

endmodule

`default_nettype wire

>>> rtl/imu_packet_deframer.sv
// Top level of the IMU packet deframer: byte shift line, packet match and angle output.
`default_nettype none

// Takes one request per cycle while not stalled. Received bytes shift into a 26-cell
// byte line whose checksum over bytes 2..24 is kept as a running 8-bit sum; the cycle
// after the byte that fills the line, the header and checksum are checked, and a match
// empties the line. A packet's result passes first the result stage, which holds the
// angle differences against the held reference, and then the output register, which
// takes them wrapped and saturated. Requests keep being accepted while a result waits downstream;
// only while the line holds 25 bytes, so that the next byte could complete a window, is
// every request held off until the result path is empty.
// Rezero and clear requests take effect at once, after any packet checked in the same
// cycle.
module imu_packet_deframer
  import ipd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  typedef struct packed {
    angle_t             yaw_diff;
    angle_t             pitch_diff;
    angle_t             roll_diff;
    logic signed [15:0] roll_rate;
    logic signed [15:0] pitch_rate;
    logic signed [15:0] yaw_rate;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } diff_t;

  logic [7:0] win [FRAME_BYTES];

  logic             in_take;
  logic             byte_take;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_eff;
  logic [7:0]       sum_q, sum_d;
  logic             full;
  logic             match;

  logic   have_q, have_d;
  angle_t ref_yaw_q, ref_yaw_d;
  angle_t ref_pitch_q, ref_pitch_d;
  angle_t ref_roll_q, ref_roll_d;
  angle_t last_yaw_q, last_yaw_d;

  angle_t roll_cur, pitch_cur, yaw_cur;

  logic  s1_valid_q, s1_valid_d;
  logic  s1_move;
  diff_t s1_q, s1_d;

  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;
  logic signed [15:0] yaw_rel, pitch_rel, roll_rel;

  // Shift line: cell 0 holds the oldest byte, the last cell the newest.
  for (genvar k = 0; k < FRAME_BYTES; k++) begin : g_cell
    if (k == FRAME_BYTES - 1) begin : g_tail
      ipd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (byte_take),
        .byte_i  (in_data_i.rx_byte),
        .byte_o  (win[k])
      );
    end else begin : g_body
      ipd_cell u_cell (
        .clk_i   (clk_i),
        .rst_ni  (rst_ni),
        .shift_i (byte_take),
        .byte_i  (win[k+1]),
        .byte_o  (win[k])
      );
    end
  end

  function automatic angle_t neg_word(logic [7:0] lo, logic [7:0] hi);
    logic signed [15:0] w;
    w = $signed({hi, lo});
    return -angle_t'(w);
  endfunction

  assign in_take   = in_valid_i && !in_stall_o;
  assign byte_take = in_take && (in_data_i.action == ACT_BYTE);

  assign full  = (cnt_q == CNT_W'(FRAME_BYTES));
  assign match = full && (win[0] == SYNC_BYTE) && (win[1] == SYNC_BYTE)
                 && (sum_q == win[FRAME_BYTES-1]);

  always_comb begin
    cnt_eff = cnt_q;
    if (full) begin
      cnt_eff = match ? '0 : CNT_W'(FRAME_BYTES - 1);
    end
    cnt_d = byte_take ? cnt_eff + CNT_W'(1) : cnt_eff;
  end

  // The sum covers cells 2..24, which after a shift are the old cells 3..25.
  assign sum_d = byte_take ? (sum_q - win[2] + win[FRAME_BYTES-1]) : sum_q;

  assign in_stall_o = (cnt_eff == CNT_W'(FRAME_BYTES - 1)) && (s1_valid_q || out_valid_q);

  assign roll_cur  = neg_word(win[3], win[4]);
  assign pitch_cur = neg_word(win[5], win[6]);
  assign yaw_cur   = neg_word(win[7], win[8]);

  always_comb begin
    have_d      = have_q;
    ref_yaw_d   = ref_yaw_q;
    ref_pitch_d = ref_pitch_q;
    ref_roll_d  = ref_roll_q;
    last_yaw_d  = last_yaw_q;
    if (match) begin
      if (!have_q) begin
        have_d      = 1'b1;
        ref_yaw_d   = yaw_cur;
        ref_pitch_d = pitch_cur;
        ref_roll_d  = roll_cur;
      end
      last_yaw_d = yaw_cur;
    end
    if (in_take) begin
      unique case (in_data_i.action)
        ACT_REZERO: ref_yaw_d = wrap_once(last_yaw_d - angle_t'(in_data_i.target_yaw));
        ACT_CLEAR:  have_d = 1'b0;
        default: ;
      endcase
    end
  end

  // Without a reference the packet becomes its own zero.
  always_comb begin
    s1_d.yaw_diff   = have_q ? (yaw_cur - ref_yaw_q) : '0;
    s1_d.pitch_diff = have_q ? (pitch_cur - ref_pitch_q) : '0;
    s1_d.roll_diff  = have_q ? (roll_cur - ref_roll_q) : '0;
    s1_d.roll_rate  = $signed({win[10], win[9]});
    s1_d.pitch_rate = $signed({win[12], win[11]});
    s1_d.yaw_rate   = $signed({win[14], win[13]});
    s1_d.accel_x    = $signed({win[16], win[15]});
    s1_d.accel_y    = $signed({win[18], win[17]});
    s1_d.accel_z    = $signed({win[20], win[19]});
  end

  assign s1_move    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign s1_valid_d = match || (s1_valid_q && !s1_move);

  ipd_rel u_rel_yaw   (.diff_i(s1_q.yaw_diff),   .rel_o(yaw_rel));
  ipd_rel u_rel_pitch (.diff_i(s1_q.pitch_diff), .rel_o(pitch_rel));
  ipd_rel u_rel_roll  (.diff_i(s1_q.roll_diff),  .rel_o(roll_rel));

  always_comb begin
    out_d            = out_q;
    out_valid_d      = out_valid_q && out_stall_i;
    if (s1_move) begin
      out_valid_d      = 1'b1;
      out_d.yaw_rel    = yaw_rel;
      out_d.pitch_rel  = pitch_rel;
      out_d.roll_rel   = roll_rel;
      out_d.roll_rate  = s1_q.roll_rate;
      out_d.pitch_rate = s1_q.pitch_rate;
      out_d.yaw_rate   = s1_q.yaw_rate;
      out_d.accel_x    = s1_q.accel_x;
      out_d.accel_y    = s1_q.accel_y;
      out_d.accel_z    = s1_q.accel_z;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sum_q       <= '0;
      have_q      <= 1'b0;
      ref_yaw_q   <= '0;
      ref_pitch_q <= '0;
      ref_roll_q  <= '0;
      last_yaw_q  <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      sum_q       <= sum_d;
      have_q      <= have_d;
      ref_yaw_q   <= ref_yaw_d;
      ref_pitch_q <= ref_pitch_d;
      ref_roll_q  <= ref_roll_d;
      last_yaw_q  <= last_yaw_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (match) begin
      s1_q <= s1_d;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // A packet found while the first result stage is still occupied would be lost.
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(match && s1_valid_q))
    else $error("packet match while result stage busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(FRAME_BYTES))
    else $error("window count beyond frame length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o |-> (out_data_o.yaw_rel <= 16'sd18000) && (out_data_o.yaw_rel >= -16'sd18000))
    else $error("yaw output outside half turn");

  assert property (@(posedge clk_i) disable iff (!rst_ni) match |=> (cnt_q <= CNT_W'(1)))
    else $error("window not emptied after packet");

endmodule

`default_nettype wire

>>> tb/sv/tb_imu_packet_deframer.sv
// Self-checking testbench for the IMU packet deframer: byte stream stimulus and a packet predictor.
`default_nettype none

module tb_imu_packet_deframer
  import ipd_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_FIELDS   = 9;
  localparam int unsigned FIELD_W      = 16;
  localparam int unsigned TARGET_ITEMS = 1650;
  localparam int unsigned TAIL_ITEMS   = 150;
  localparam int unsigned DRAIN_CYCLES = 20;

  // Action code that the block ignores.
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic [15:0] frame_words_t [NUM_FIELDS];

  typedef enum int {
    PKT_GOOD,
    PKT_BAD_SUM,
    PKT_BAD_SYNC
  } pkt_kind_e;

  // Predicts deframer results and matches them against the output stream.
  class imu_frame_scoreboard;
    logic [7:0]  window [FRAME_BYTES];
    int unsigned fill;
    bit          have_ref;
    int          ref_yaw;
    int          ref_pitch;
    int          ref_roll;
    int          last_yaw;
    out_t        pending_q [$];
    int unsigned mismatches;
    int unsigned packets_found;
    int unsigned results_seen;
    string       field_names [NUM_FIELDS] = '{"yaw_rel", "pitch_rel", "roll_rel",
                                              "roll_rate", "pitch_rate", "yaw_rate",
                                              "accel_x", "accel_y", "accel_z"};

    function new();
      foreach (window[k]) window[k] = 8'h00;
      fill          = 0;
      have_ref      = 1'b0;
      ref_yaw       = 0;
      ref_pitch     = 0;
      ref_roll      = 0;
      last_yaw      = 0;
      mismatches    = 0;
      packets_found = 0;
      results_seen  = 0;
    endfunction

    function int word_at(int unsigned pos);
      logic signed [15:0] w;
      w = {window[pos + 1], window[pos]};
      return w;
    endfunction

    function int fold_half_turn(int d);
      int r;
      r = d;
      if (r > HALF_TURN) r = r - FULL_TURN;
      if (r < -HALF_TURN) r = r + FULL_TURN;
      return r;
    endfunction

    function int rel_angle(int cur, int base);
      int d;
      d = fold_half_turn(cur - base);
      if (d > HALF_TURN) d = HALF_TURN;
      if (d < -HALF_TURN) d = -HALF_TURN;
      return d;
    endfunction

    function bit window_matches();
      logic [7:0] sum;
      sum = 8'h00;
      if (window[0] != SYNC_BYTE || window[1] != SYNC_BYTE) return 1'b0;
      for (int k = 2; k < FRAME_BYTES - 1; k++) sum = sum + window[k];
      return sum == window[FRAME_BYTES - 1];
    endfunction

    // Advances the predicted state by one accepted request.
    function void note_request(in_t req);
      int   roll;
      int   pitch;
      int   yaw;
      int   target;
      out_t exp;
      target = req.target_yaw;
      case (req.action)
        ACT_REZERO: ref_yaw = fold_half_turn(last_yaw - target);
        ACT_CLEAR:  have_ref = 1'b0;
        ACT_BYTE: begin
          if (fill >= FRAME_BYTES) fill = FRAME_BYTES - 1;
          window[fill] = req.rx_byte;
          fill++;
          if (fill == FRAME_BYTES) begin
            if (!window_matches()) begin
              for (int k = 0; k < FRAME_BYTES - 1; k++) window[k] = window[k + 1];
              fill = FRAME_BYTES - 1;
            end else begin
              roll  = -word_at(3);
              pitch = -word_at(5);
              yaw   = -word_at(7);
              if (!have_ref) begin
                have_ref  = 1'b1;
                ref_yaw   = yaw;
                ref_pitch = pitch;
                ref_roll  = roll;
              end
              last_yaw       = yaw;
              exp.yaw_rel    = 16'(rel_angle(yaw, ref_yaw));
              exp.pitch_rel  = 16'(rel_angle(pitch, ref_pitch));
              exp.roll_rel   = 16'(rel_angle(roll, ref_roll));
              exp.roll_rate  = 16'(word_at(9));
              exp.pitch_rate = 16'(word_at(11));
              exp.yaw_rate   = 16'(word_at(13));
              exp.accel_x    = 16'(word_at(15));
              exp.accel_y    = 16'(word_at(17));
              exp.accel_z    = 16'(word_at(19));
              pending_q.push_back(exp);
              packets_found++;
              fill = 0;
            end
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task check_result(out_t got);
      out_t exp;
      int   hi;
      if (pending_q.size() == 0) begin
        report_mismatch("result arrived with no packet pending");
        return;
      end
      exp = pending_q.pop_front();
      results_seen++;
      for (int f = 0; f < NUM_FIELDS; f++) begin
        hi = $bits(out_t) - 1 - FIELD_W * f;
        if (got[hi -: FIELD_W] !== exp[hi -: FIELD_W]) begin
          report_mismatch($sformatf("packet %0d %s: got %0d, expected %0d", results_seen,
                                    field_names[f], $signed(got[hi -: FIELD_W]),
                                    $signed(exp[hi -: FIELD_W])));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  imu_frame_scoreboard sb;
  int unsigned items_sent;
  int unsigned in_gap_pct;
  bit          quiet;

  imu_packet_deframer i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(out_data_o);
    end
  end

  // Output back-pressure in random bursts, switched off for the tail of the run.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!quiet && $urandom_range(0, 11) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 14)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("ERROR: run did not drain in time, %0d packets still pending", sb.pending_q.size());
    $display("tb_imu_packet_deframer failed");
    $finish;
  end

  task automatic send_request(in_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
    items_sent++;
    if (items_sent > TARGET_ITEMS - TAIL_ITEMS) quiet = 1'b1;
    if (!quiet && $urandom_range(0, 99) < in_gap_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 14) - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_byte(logic [7:0] b);
    in_t req;
    req.action     = ACT_BYTE;
    req.rx_byte    = b;
    req.target_yaw = 16'($urandom);
    send_request(req);
  endtask

  task automatic send_control(logic [1:0] code, logic signed [15:0] target);
    in_t req;
    req.action     = action_e'(code);
    req.rx_byte    = 8'($urandom);
    req.target_yaw = target;
    send_request(req);
  endtask

  function automatic logic signed [15:0] pick_target();
    return 16'($signed($urandom_range(0, 2 * HALF_TURN)) - HALF_TURN);
  endfunction

  function automatic logic [15:0] pick_word(bit is_angle);
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return is_angle ? 16'(HALF_TURN) : 16'hFFFF;
      3: return is_angle ? 16'(-HALF_TURN) : 16'h0000;
      4, 5: return is_angle ? 16'(pick_target()) : 16'($urandom);
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one framed packet; control requests may be slipped in between its bytes.
  task automatic send_packet(frame_words_t words, pkt_kind_e kind, int unsigned ctrl_pct);
    logic [7:0] bytes [FRAME_BYTES];
    logic [7:0] sum;
    bytes[0] = SYNC_BYTE;
    bytes[1] = SYNC_BYTE;
    bytes[2] = 8'($urandom);
    for (int k = 0; k < NUM_FIELDS; k++) begin
      bytes[3 + 2 * k] = words[k][7:0];
      bytes[4 + 2 * k] = words[k][15:8];
    end
    for (int k = 21; k < FRAME_BYTES - 1; k++) bytes[k] = 8'($urandom);
    sum = 8'h00;
    for (int k = 2; k < FRAME_BYTES - 1; k++) sum = sum + bytes[k];
    bytes[FRAME_BYTES - 1] = sum;
    if (kind == PKT_BAD_SUM) bytes[FRAME_BYTES - 1] = sum + 8'($urandom_range(1, 255));
    if (kind == PKT_BAD_SYNC) bytes[$urandom_range(0, 1)] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
    for (int k = 0; k < FRAME_BYTES; k++) begin
      if ($urandom_range(0, 99) < ctrl_pct) begin
        send_control(2'($urandom_range(ACT_REZERO, ACT_UNUSED)), pick_target());
      end
      send_byte(bytes[k]);
    end
  endtask

  task automatic send_random_packet(pkt_kind_e kind);
    frame_words_t w;
    for (int k = 0; k < NUM_FIELDS; k++) w[k] = pick_word(k < 3);
    send_packet(w, kind, $urandom_range(0, 1) ? 0 : 3);
  endtask

  initial begin
    frame_words_t w;
    int unsigned  sel;
    sb          = new();
    items_sent  = 0;
    in_gap_pct  = 0;
    quiet       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: unused code and clear on an empty window, rezero before any
    // reference, full-scale words, saturation, both rezero extremes, broken frames.
    send_control(ACT_UNUSED, 16'sh7FFF);
    send_control(ACT_CLEAR, 16'sh8000);
    send_control(ACT_REZERO, 16'sd5000);
    w = '{16'h7FFF, 16'h8000, 16'h1234, 16'h8000, 16'h7FFF, 16'h0000,
          16'hFFFF, 16'h0001, 16'h8000};
    send_packet(w, PKT_GOOD, 0);
    w[0] = 16'h8000;
    w[1] = 16'h7FFF;
    w[2] = 16'(-HALF_TURN);
    send_packet(w, PKT_GOOD, 0);
    send_control(ACT_REZERO, 16'(HALF_TURN));
    send_packet(w, PKT_GOOD, 0);
    send_control(ACT_REZERO, 16'(-HALF_TURN));
    w[2] = 16'(HALF_TURN);
    send_packet(w, PKT_GOOD, 0);
    send_packet(w, PKT_BAD_SUM, 0);
    send_byte(SYNC_BYTE);
    send_packet(w, PKT_GOOD, 0);
    send_control(ACT_CLEAR, 16'sd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_packet(w, PKT_BAD_SYNC, 0);
    send_packet(w, PKT_GOOD, 0);

    // Random part: mostly well-formed packets with noise, broken frames and controls.
    while (items_sent < TARGET_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: in_gap_pct = 0;
          1: in_gap_pct = 5;
          default: in_gap_pct = 25;
        endcase
      end
      sel = $urandom_range(0, 99);
      if (sel < 62) begin
        repeat ($urandom_range(0, 2)) send_byte($urandom_range(0, 3) == 0 ? SYNC_BYTE
                                                                          : 8'($urandom));
        send_random_packet(PKT_GOOD);
      end else if (sel < 72) begin
        send_random_packet($urandom_range(0, 1) ? PKT_BAD_SUM : PKT_BAD_SYNC);
      end else if (sel < 82) begin
        repeat ($urandom_range(1, 30)) send_byte($urandom_range(0, 2) == 0 ? SYNC_BYTE
                                                                           : 8'($urandom));
      end else if (sel < 92) begin
        send_control(ACT_REZERO, pick_target());
      end else if (sel < 97) begin
        send_control(ACT_CLEAR, 16'($urandom));
      end else begin
        send_control(ACT_UNUSED, 16'($urandom));
      end
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests; %0d packets predicted, %0d results checked.",
             items_sent, sb.packets_found, sb.results_seen);
    $display("Covered full-scale angles, saturation, rezero and clear, broken frames, noise.");
    if (sb.mismatches == 0) begin
      $display("tb_imu_packet_deframer passed");
    end else begin
      $display("tb_imu_packet_deframer failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
rtl/ipd_pkg.sv
rtl/ipd_cell.sv
rtl/ipd_rel.sv
rtl/imu_packet_deframer.sv
tb/sv/tb_imu_packet_deframer.sv
